/* rtl/core/srds_pkg.sv */
// shared types and constants of the shortest-remaining download scheduler
package srds_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int BUDGET_W = 48;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_WAIT = 1'b1;

	localparam logic [1:0] KIND_ADDED = 2'd0;
	localparam logic [1:0] KIND_REJECTED = 2'd1;
	localparam logic [1:0] KIND_COMPLETED = 2'd2;
	localparam logic [1:0] KIND_WAIT_DONE = 2'd3;

	typedef struct packed {
		logic                is_wait;
		logic [7:0]          id;
		logic [31:0]         size;
		logic [31:0]         left;
		logic [BUDGET_W-1:0] budget;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_DRAIN
	} back_state_t;

endpackage

/* rtl/core/shortest_remaining_download_scheduler.sv */
// top level of the shortest-remaining download scheduler
// an accepted add passes through the front queue, then the result register, to the output
// a wait loads its budget, then takes one head step at a time (each finished transfer, or
// a partly served head), then emits the closing item; the drain loop sets the wait rate
// throughput: adds sustain one item per cycle while results are taken and no wait drains
// reset: queue empty, bandwidth 0, no results pending; entries are not cleared
module shortest_remaining_download_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	// bandwidth register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// command items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  transfer_id,
	input  logic [31:0] total_bytes,
	input  logic [31:0] done_bytes,
	input  logic [15:0] seconds,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  done_id,
	output logic [31:0] done_size,
	output logic [4:0]  pending,
	output logic        last
);

	// front to back command queue
	logic cq_valid, cq_ready;
	srds_pkg::cmd_t cq_data;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// front: remaining bytes, bandwidth times seconds, two-entry queue
	srds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.transfer_id(transfer_id),
		.total_bytes(total_bytes),
		.done_bytes (done_bytes),
		.seconds    (seconds),
		.cq_valid   (cq_valid),
		.cq_ready   (cq_ready),
		.cq_data    (cq_data)
	);

	// back: sorted insert, drain one head step per cycle while the result register is free
	srds_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_valid (cq_valid),
		.cq_ready (cq_ready),
		.cq_data  (cq_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.done_id  (done_id),
		.done_size(done_size),
		.pending  (pending),
		.last     (last)
	);

endmodule

/* rtl/core/srds_front.sv */
// front end: takes items, forms remaining bytes and budget, queues commands
module srds_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [7:0]          transfer_id,
	input  logic [31:0]         total_bytes,
	input  logic [31:0]         done_bytes,
	input  logic [15:0]         seconds,
	output logic                cq_valid,
	input  logic                cq_ready,
	output srds_pkg::cmd_t      cq_data
);

	logic [31:0] bandwidth_q;
	srds_pkg::cmd_t fifo_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	srds_pkg::cmd_t entry;
	logic push, pop;

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign pop = cq_valid && cq_ready;
	assign cq_valid = (count_q != 2'd0);
	assign cq_data = fifo_q[rd_ptr_q];

	always_comb begin
		entry.is_wait = cmd;
		entry.id = transfer_id;
		entry.size = total_bytes;
		// saturate at zero when more is done than the total
		entry.left = (done_bytes > total_bytes) ? 32'd0 : (total_bytes - done_bytes);
		entry.budget = bandwidth_q * seconds;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bandwidth_q <= 32'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (cfg_valid) begin
				bandwidth_q <= cfg_data;
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

endmodule

/* rtl/core/srds_back.sv */
// back end: sorted transfer queue, wait drain and result register
module srds_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cq_valid,
	output logic           cq_ready,
	input  srds_pkg::cmd_t cq_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     kind,
	output logic [7:0]     done_id,
	output logic [31:0]    done_size,
	output logic [4:0]     pending,
	output logic           last
);

	localparam int D = srds_pkg::QUEUE_DEPTH;
	localparam int OW = srds_pkg::OCC_W;

	srds_pkg::back_state_t state_q, state_d;
	logic [7:0]  slot_id_q   [D];
	logic [31:0] slot_size_q [D];
	logic [31:0] slot_left_q [D];
	logic [OW-1:0] occ_q;
	logic [srds_pkg::BUDGET_W-1:0] budget_q;

	logic out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] id_q;
	logic [31:0] size_q;
	logic [OW-1:0] pend_q;
	logic last_q;

	logic out_free, full, empty;
	logic [D-1:0] ins_ahead;
	logic [srds_pkg::BUDGET_W-1:0] head_left;
	logic head_covers;
	logic [31:0] head_rest;

	// control decoded in the output block
	logic do_insert, do_load, do_pop, do_trim, emit, emit_last;
	logic [1:0] emit_kind;
	logic [7:0] emit_id;
	logic [31:0] emit_size;
	logic [OW-1:0] emit_pend;
	logic [OW+4:0] pend_ext;

	assign out_free = !out_valid_q || out_ready;
	assign full = (occ_q >= OW'(D));
	assign empty = (occ_q == '0);
	assign head_left = {{(srds_pkg::BUDGET_W-32){1'b0}}, slot_left_q[0]};
	assign head_covers = (head_left >= budget_q);
	assign head_rest = slot_left_q[0] - budget_q[31:0];

	always_comb begin
		for (int j = 0; j < D; j++) begin
			ins_ahead[j] = (OW'(j) < occ_q) && (cq_data.left > slot_left_q[j]);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			srds_pkg::BK_IDLE: begin
				if (cq_valid && out_free && cq_data.is_wait == srds_pkg::CMD_WAIT) begin
					state_d = srds_pkg::BK_DRAIN;
				end
			end
			srds_pkg::BK_DRAIN: begin
				if (out_free && (budget_q == '0 || empty)) begin
					state_d = srds_pkg::BK_IDLE;
				end
			end
			default: state_d = srds_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cq_ready = 1'b0;
		do_insert = 1'b0;
		do_load = 1'b0;
		do_pop = 1'b0;
		do_trim = 1'b0;
		emit = 1'b0;
		emit_last = 1'b0;
		emit_kind = srds_pkg::KIND_ADDED;
		emit_id = cq_data.id;
		emit_size = cq_data.size;
		emit_pend = occ_q;
		case (state_q)
			srds_pkg::BK_IDLE: begin
				if (out_free) begin
					cq_ready = 1'b1;
					if (cq_valid && cq_data.is_wait == srds_pkg::CMD_WAIT) begin
						do_load = 1'b1;
					end else if (cq_valid) begin
						emit = 1'b1;
						emit_last = 1'b1;
						if (full) begin
							emit_kind = srds_pkg::KIND_REJECTED;
						end else begin
							do_insert = 1'b1;
							emit_pend = occ_q + 1'b1;
						end
					end
				end
			end
			srds_pkg::BK_DRAIN: begin
				emit_id = slot_id_q[0];
				emit_size = slot_size_q[0];
				if (out_free) begin
					if (budget_q == '0 || empty) begin
						emit = 1'b1;
						emit_last = 1'b1;
						emit_kind = srds_pkg::KIND_WAIT_DONE;
						emit_id = 8'd0;
						emit_size = 32'd0;
					end else if (head_covers && head_rest != 32'd0) begin
						// head only partly served, budget used up
						do_trim = 1'b1;
					end else begin
						do_pop = 1'b1;
						emit = 1'b1;
						emit_kind = srds_pkg::KIND_COMPLETED;
						emit_pend = occ_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srds_pkg::BK_IDLE;
			occ_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_insert) begin
				occ_q <= occ_q + 1'b1;
			end else if (do_pop) begin
				occ_q <= occ_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= emit_kind;
			id_q <= emit_id;
			size_q <= emit_size;
			pend_q <= emit_pend;
			last_q <= emit_last;
		end
		if (do_load) begin
			budget_q <= cq_data.budget;
		end else if (do_trim) begin
			budget_q <= '0;
		end else if (do_pop) begin
			budget_q <= head_covers ? '0 : (budget_q - head_left);
		end
		if (do_trim) begin
			slot_left_q[0] <= head_rest;
		end
		for (int j = 0; j < D; j++) begin
			if (do_insert && !ins_ahead[j]) begin
				if (j == 0 || ins_ahead[(j == 0) ? 0 : j-1]) begin
					slot_id_q[j] <= cq_data.id;
					slot_size_q[j] <= cq_data.size;
					slot_left_q[j] <= cq_data.left;
				end else begin
					slot_id_q[j] <= slot_id_q[(j == 0) ? 0 : j-1];
					slot_size_q[j] <= slot_size_q[(j == 0) ? 0 : j-1];
					slot_left_q[j] <= slot_left_q[(j == 0) ? 0 : j-1];
				end
			end else if (do_pop && j < D-1) begin
				slot_id_q[j] <= slot_id_q[(j < D-1) ? j+1 : j];
				slot_size_q[j] <= slot_size_q[(j < D-1) ? j+1 : j];
				slot_left_q[j] <= slot_left_q[(j < D-1) ? j+1 : j];
			end
		end
	end

	assign pend_ext = {5'd0, pend_q};
	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign done_id = id_q;
	assign done_size = size_q;
	assign pending = pend_ext[4:0];
	assign last = last_q;

endmodule

/* rtl/core/srds_checker.sv */
// port-level checks of the scheduler, bound to the top level
module srds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  done_id,
	input logic [31:0] done_size,
	input logic [4:0]  pending,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_wait_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == srds_pkg::KIND_WAIT_DONE |->
			last && done_id == 8'd0 && done_size == 32'd0)
		else $error("bad closing result");

	a_complete_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == srds_pkg::KIND_COMPLETED |-> !last)
		else $error("completion marked last");

	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == srds_pkg::KIND_ADDED |-> pending != 5'd0)
		else $error("added with empty queue");

endmodule

bind shortest_remaining_download_scheduler srds_checker u_srds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.kind     (kind),
	.done_id  (done_id),
	.done_size(done_size),
	.pending  (pending),
	.last     (last)
);
